// ===== src/rgp_pkg.sv =====
// ----------------------------------------------------------------------------
// rgp_pkg
// Shared types and constants of the radial gradient pixel block.
// ----------------------------------------------------------------------------
package rgp_pkg;

  localparam int MAX_DIM_DEF = 2048;

  localparam int COORD_W = 11;
  localparam int DIM_W   = 12;
  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int CFG_IDX_W = 3;

  localparam int T_FRAC = 16;
  localparam int T_W    = T_FRAC + 1;
  localparam logic [T_W-1:0] T_ONE = T_W'(1 << T_FRAC);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH     = 3'd0,
    CFG_IMAGE_HEIGHT    = 3'd1,
    CFG_GRADIENT_RADIUS = 3'd2,
    CFG_OUTER_COLOR     = 3'd3,
    CFG_INNER_COLOR     = 3'd4
  } cfg_idx_t;

endpackage

// ===== src/rgp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rgp_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface rgp_cfg_if import rgp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COLOR_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/rgp_pix_if.sv =====
// ----------------------------------------------------------------------------
// rgp_pix_if
// Pixel coordinate channel.
// ----------------------------------------------------------------------------
interface rgp_pix_if import rgp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;

  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

// ===== src/rgp_rgb_if.sv =====
// ----------------------------------------------------------------------------
// rgp_rgb_if
// Blended color channel.
// ----------------------------------------------------------------------------
interface rgp_rgb_if import rgp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== src/radial_gradient_pixel.sv =====
// ----------------------------------------------------------------------------
// radial_gradient_pixel
// Color of one pixel of a radial gradient around the image center.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   cfg      in   index, data (register writes)
//   pix      in   pixel_x, pixel_y
//   rgb      out  red, green, blue
//
// one pixel per cycle; the square root yields one root bit per stage and the
// divider one quotient bit per stage. the whole pipe advances together and
// halts while a result waits on rgb. reset clears all valid bits and loads
// register defaults.
module radial_gradient_pixel
  import rgp_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic     clk,
  input  logic     rst,
  rgp_cfg_if.sink  cfg,
  rgp_pix_if.sink  pix,
  rgp_rgb_if.source rgb
);

  localparam int CW   = $clog2(MAX_DIM);
  localparam int AW   = (CW > COORD_W) ? CW : COORD_W;
  localparam int R2W  = 2 * AW + 1;
  localparam int SQW  = AW + 9;
  localparam int RADW = 2 * SQW;
  localparam int NW   = SQW + 9;
  localparam int CLW  = $clog2(MAX_DIM + 1);

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [DIM_W-1:0]   gradient_radius;
  logic [COLOR_W-1:0] outer_color;
  logic [COLOR_W-1:0] inner_color;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= DIM_W'(256);
      image_height    <= DIM_W'(256);
      gradient_radius <= DIM_W'(128);
      outer_color     <= '0;
      inner_color     <= '1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_IMAGE_WIDTH:     image_width     <= cfg.data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:    image_height    <= cfg.data[DIM_W-1:0];
        CFG_GRADIENT_RADIUS: gradient_radius <= cfg.data[DIM_W-1:0];
        CFG_OUTER_COLOR:     outer_color     <= cfg.data;
        CFG_INNER_COLOR:     inner_color     <= cfg.data;
        default: ;
      endcase
    end
  end

  // center, dimension clamped to MAX_DIM
  logic [CLW-1:0] clamp_w, clamp_h;
  logic [CW-1:0]  cx, cy;

  always_comb begin
    clamp_w = ({1'b0, image_width} > (DIM_W+1)'(MAX_DIM)) ? CLW'(MAX_DIM)
                                                          : CLW'(image_width);
    clamp_h = ({1'b0, image_height} > (DIM_W+1)'(MAX_DIM)) ? CLW'(MAX_DIM)
                                                           : CLW'(image_height);
    cx = CW'(clamp_w >> 1);
    cy = CW'(clamp_h >> 1);
  end

  logic en;
  logic out_valid;
  assign en        = !out_valid || rgb.ready;
  assign pix.ready = en;

  // stage a: signed offsets
  logic                a_v;
  logic signed [AW:0]  a_dx, a_dy;
  // stage b: magnitudes
  logic                b_v;
  logic [AW-1:0]       b_ax, b_ay;
  // stage c: squares
  logic                c_v;
  logic [2*AW-1:0]     c_sx, c_sy;
  // stage d: squared distance
  logic                d_v;
  logic [R2W-1:0]      d_r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else if (en) begin
      a_v <= pix.valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx <= $signed({1'b0, AW'(pix.pixel_x)}) - $signed({1'b0, AW'(cx)});
      a_dy <= $signed({1'b0, AW'(pix.pixel_y)}) - $signed({1'b0, AW'(cy)});
      b_ax <= a_dx[AW] ? AW'(-a_dx) : a_dx[AW-1:0];
      b_ay <= a_dy[AW] ? AW'(-a_dy) : a_dy[AW-1:0];
      c_sx <= b_ax * b_ax;
      c_sy <= b_ay * b_ay;
      d_r2 <= R2W'(c_sx) + R2W'(c_sy);
    end
  end

  // square root of r2 << 16, one root bit per stage
  logic           s_v    [0:SQW];
  logic [SQW+1:0] s_rem  [0:SQW];
  logic [SQW-1:0] s_root [0:SQW];
  logic [RADW-1:0] s_rad [0:SQW];

  assign s_v[0]    = d_v;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_rad[0]  = RADW'({d_r2, 16'b0});

  for (genvar j = 0; j < SQW; j++) begin : g_sqrt
    logic [SQW+1:0] rem_w, trial;
    logic           fit;
    always_comb begin
      rem_w = {s_rem[j][SQW-1:0], s_rad[j][RADW-1 -: 2]};
      trial = {s_root[j], 2'b01};
      fit   = rem_w >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        s_v[j+1] <= 1'b0;
      end else if (en) begin
        s_v[j+1] <= s_v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s_rem[j+1]  <= fit ? rem_w - trial : rem_w;
        s_root[j+1] <= {s_root[j][SQW-2:0], fit};
        s_rad[j+1]  <= s_rad[j] << 2;
      end
    end
  end

  // division (r << 8) / radius, one quotient bit per stage
  localparam int QB = T_W;
  logic          q_v   [0:QB];
  logic [NW-1:0] q_num [0:QB];
  logic          q_sat [0:QB];
  logic [QB-1:0] q_q   [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v[0] <= 1'b0;
    end else if (en) begin
      q_v[0] <= s_v[SQW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_num[0] <= NW'({s_root[SQW], 8'b0});
      q_sat[0] <= NW'({s_root[SQW], 8'b0}) >= (NW'(gradient_radius) << QB);
      q_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [NW-1:0] dsh;
    logic          fit;
    always_comb begin
      dsh = NW'(gradient_radius) << (QB - 1 - j);
      fit = !q_sat[j] && (q_num[j] >= dsh);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        q_v[j+1] <= 1'b0;
      end else if (en) begin
        q_v[j+1] <= q_v[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q_num[j+1] <= fit ? q_num[j] - dsh : q_num[j];
        q_sat[j+1] <= q_sat[j];
        q_q[j+1]   <= {q_q[j][QB-2:0], fit};
      end
    end
  end

  // blend
  logic                  t_v, m_v;
  logic [T_W-1:0]        t;
  logic [T_W+CHAN_W-1:0] m_or, m_og, m_ob, m_ir, m_ig, m_ib;
  logic [CHAN_W-1:0]     o_r, o_g, o_b;
  logic [T_W-1:0]        t_inv;

  assign t_inv = T_ONE - t;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v       <= 1'b0;
      m_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      t_v       <= q_v[QB];
      m_v       <= t_v;
      out_valid <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t    <= (q_sat[QB] || (q_q[QB] > T_ONE)) ? T_ONE : q_q[QB];
      m_or <= t * outer_color[23:16];
      m_og <= t * outer_color[15:8];
      m_ob <= t * outer_color[7:0];
      m_ir <= t_inv * inner_color[23:16];
      m_ig <= t_inv * inner_color[15:8];
      m_ib <= t_inv * inner_color[7:0];
      o_r  <= CHAN_W'((m_or + m_ir) >> T_FRAC);
      o_g  <= CHAN_W'((m_og + m_ig) >> T_FRAC);
      o_b  <= CHAN_W'((m_ob + m_ib) >> T_FRAC);
    end
  end

  assign rgb.valid = out_valid;
  assign rgb.red   = o_r;
  assign rgb.green = o_g;
  assign rgb.blue  = o_b;

endmodule

// ===== src/rgp_chk.sv =====
// ----------------------------------------------------------------------------
// rgp_chk
// Port checker for radial_gradient_pixel.
// ----------------------------------------------------------------------------
module rgp_chk
  import rgp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              cfg_ready,
  input logic              pix_ready,
  input logic              rgb_valid,
  input logic              rgb_ready,
  input logic [CHAN_W-1:0] red,
  input logic [CHAN_W-1:0] green,
  input logic [CHAN_W-1:0] blue
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && !rgb_ready |=> rgb_valid && $stable(red) && $stable(green)
                                && $stable(blue))
    else $error("stalled result changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !rgb_valid |-> pix_ready)
    else $error("input blocked with empty output");

  a_flow_ready: assert property (@(posedge clk) disable iff (rst)
    rgb_ready |-> pix_ready)
    else $error("input blocked while output drains");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("register port not ready");

endmodule

bind radial_gradient_pixel rgp_chk u_rgp_chk (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg.ready),
  .pix_ready (pix.ready),
  .rgb_valid (rgb.valid),
  .rgb_ready (rgb.ready),
  .red       (rgb.red),
  .green     (rgb.green),
  .blue      (rgb.blue)
);

// ===== test/tb_radial_gradient_pixel.sv =====
// ----------------------------------------------------------------------------
// tb_radial_gradient_pixel
// Self-checking bench for the radial gradient block: register writes over the
// cfg channel, pixel transfers with random gaps on both sides, and an
// internal predictor of the gradient color compared field by field per result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_radial_gradient_pixel;
  import rgp_pkg::*;

  localparam int LATENCY   = 11 + 34;
  localparam int WDOG_MAX  = 20000;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  logic clk;
  logic rst;

  rgp_cfg_if cfg ();
  rgp_pix_if pix ();
  rgp_rgb_if rgb ();

  radial_gradient_pixel dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg.sink),
    .pix(pix.sink),
    .rgb(rgb.source)
  );

  logic [DIM_W-1:0]   width_reg;
  logic [DIM_W-1:0]   height_reg;
  logic [DIM_W-1:0]   radius_reg;
  logic [COLOR_W-1:0] outer_reg;
  logic [COLOR_W-1:0] inner_reg;

  rgb_t color_queue[$];
  int   errors;
  int   n_pixels;
  int   n_colors;
  int   n_cfg;
  int   idle_cycles;
  logic sink_stall_en;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [CHAN_W-1:0] mix_chan(input logic [16:0] t,
                                                 input logic [7:0] o,
                                                 input logic [7:0] i);
    logic [63:0] acc;
    acc = 64'(t) * o + 64'(17'h10000 - t) * i;
    return acc[23:16];
  endfunction

  function automatic rgb_t gradient_color(input logic [COORD_W-1:0] px,
                                          input logic [COORD_W-1:0] py);
    longint cx, cy, dx, dy;
    logic [63:0] r2, rq, q;
    logic [16:0] t;
    rgb_t c;
    cx = ((width_reg > 2048) ? 2048 : width_reg) / 2;
    cy = ((height_reg > 2048) ? 2048 : height_reg) / 2;
    dx = longint'(px) - cx;
    dy = longint'(py) - cy;
    r2 = dx * dx + dy * dy;
    rq = int_sqrt(r2 << 16);
    if (radius_reg == 0) begin
      t = 17'h10000;
    end else begin
      q = (rq << 8) / radius_reg;
      t = (q > 64'h10000) ? 17'h10000 : q[16:0];
    end
    c.red   = mix_chan(t, outer_reg[23:16], inner_reg[23:16]);
    c.green = mix_chan(t, outer_reg[15:8], inner_reg[15:8]);
    c.blue  = mix_chan(t, outer_reg[7:0], inner_reg[7:0]);
    return c;
  endfunction

  // leaves valid high, the caller lowers it after the last write
  task automatic write_reg(input cfg_idx_t idx, input logic [COLOR_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    unique case (idx)
      CFG_IMAGE_WIDTH:     width_reg  = val[DIM_W-1:0];
      CFG_IMAGE_HEIGHT:    height_reg = val[DIM_W-1:0];
      CFG_GRADIENT_RADIUS: radius_reg = val[DIM_W-1:0];
      CFG_OUTER_COLOR:     outer_reg  = val;
      CFG_INNER_COLOR:     inner_reg  = val;
      default: ;
    endcase
    n_cfg++;
  endtask

  // leaves valid high so transfers can follow back to back
  task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid   <= 1'b1;
    pix.pixel_x <= px;
    pix.pixel_y <= py;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    color_queue = {color_queue, gradient_color(px, py)};
    n_pixels++;
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (color_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic setup(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                       input logic [DIM_W-1:0] r, input logic [COLOR_W-1:0] o,
                       input logic [COLOR_W-1:0] i);
    drain();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_GRADIENT_RADIUS, r);
    write_reg(CFG_OUTER_COLOR, o);
    write_reg(CFG_INNER_COLOR, i);
    cfg.valid <= 1'b0;
  endtask

  // reset defaults, center and far corners
  task automatic test_defaults();
    send_pixel(128, 128, 0);
    send_pixel(0, 0, 0);
    send_pixel(2047, 2047, 0);
    send_pixel(192, 128, 0);
    send_pixel(1365, 682, 0);
  endtask

  task automatic test_edge_settings();
    setup(4, 1, 1, 24'h123456, 24'hFEDCBA);
    send_pixel(2, 0, 0);
    send_pixel(3, 0, 0);
    send_pixel(0, 2047, 0);
    setup(12'hFFF, 12'hFFF, 12'hFFF, 24'hFFFFFF, 24'h000000);
    send_pixel(1024, 1024, 0);
    send_pixel(0, 0, 0);
    send_pixel(2047, 0, 0);
    setup(2048, 2048, 0, 24'hA5A5A5, 24'h5A5A5A);
    send_pixel(1024, 1024, 0);
    send_pixel(77, 300, 0);
    setup(101, 37, 13, 24'h00FF00, 24'hFF00FF);
    send_pixel(50, 18, 0);
    send_pixel(55, 18, 0);
    send_pixel(50, 30, 0);
    send_pixel(2047, 2047, 0);
  endtask

  task automatic test_random();
    int k;
    for (int ph = 0; ph < 13; ph++) begin
      setup(ph == 0 ? 12'd2048 : 12'($urandom_range(4, 4095)),
            ph == 1 ? 12'd1 : 12'($urandom_range(1, 4095)),
            ph == 2 ? 12'd0 : (ph == 3 ? 12'hFFF : 12'($urandom_range(1, 600))),
            24'($urandom), 24'($urandom));
      sink_stall_en = (ph % 3 != 2);
      for (k = 0; k < 150; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_pixel(11'($urandom), 11'($urandom), ph % 3 != 2);
        else
          send_pixel(11'(width_reg / 2 + $urandom_range(0, 2 * radius_reg + 2)
                         - radius_reg - 1),
                     11'(height_reg / 2 + $urandom_range(0, 2 * radius_reg + 2)
                         - radius_reg - 1), ph % 3 != 2);
      end
    end
    sink_stall_en = 1'b1;
  endtask

  // result side: random stalls and field compare
  initial begin
    int stall;
    rgb.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = sink_stall_en ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        rgb.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rgb.ready <= 1'b1;
      @(posedge clk);
      while (!rgb.valid) @(posedge clk);
      if (color_queue.size() == 0) begin
        $display("%0t: unexpected transfer r=%h g=%h b=%h", $time,
                 rgb.red, rgb.green, rgb.blue);
        errors++;
      end else begin
        rgb_t exp_c;
        exp_c = color_queue.pop_front();
        if (rgb.red !== exp_c.red) begin
          $display("%0t: red expected %h actual %h", $time, exp_c.red, rgb.red);
          errors++;
        end
        if (rgb.green !== exp_c.green) begin
          $display("%0t: green expected %h actual %h", $time, exp_c.green, rgb.green);
          errors++;
        end
        if (rgb.blue !== exp_c.blue) begin
          $display("%0t: blue expected %h actual %h", $time, exp_c.blue, rgb.blue);
          errors++;
        end
      end
      n_colors++;
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (rgb.valid && rgb.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog expired with %0d results pending", color_queue.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    errors = 0; n_pixels = 0; n_colors = 0; n_cfg = 0; idle_cycles = 0;
    sink_stall_en = 1'b1;
    width_reg = 256; height_reg = 256; radius_reg = 128;
    outer_reg = 24'h000000; inner_reg = 24'hFFFFFF;
    rst = 1'b1;
    cfg.valid = 1'b0; cfg.index = CFG_IMAGE_WIDTH; cfg.data = '0;
    pix.valid = 1'b0; pix.pixel_x = '0; pix.pixel_y = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_edge_settings();
    test_random();
    drain();
    $display("pixels sent %0d, colors checked %0d, register writes %0d",
             n_pixels, n_colors, n_cfg);
    if (errors == 0 && color_queue.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
